[hdl/double_ended_queue_with_removal_core_macros.svh]
// Assertion macros used by the checker of this block.
`ifndef DOUBLE_ENDED_QUEUE_WITH_REMOVAL_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_REMOVAL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/dqr_pkg.sv]
package dqr_pkg;

	localparam int DEFAULT_DEPTH      = 16;
	localparam int DEFAULT_DATA_WIDTH = 32;

	localparam logic [2:0] CMD_APPEND_BACK  = 3'd0;
	localparam logic [2:0] CMD_INSERT_FRONT = 3'd1;
	localparam logic [2:0] CMD_TAKE_FRONT   = 3'd2;
	localparam logic [2:0] CMD_TAKE_BACK    = 3'd3;
	localparam logic [2:0] CMD_DELETE_MATCH = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] item_value;
		logic [4:0]  remove_limit;
	} dqr_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] taken_value;
		logic [4:0]  deleted_count;
		logic [4:0]  entry_count;
		logic        is_empty;
		logic [31:0] front_value;
		logic [31:0] back_value;
	} dqr_rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_PUSH,
		CELL_PULL
	} cell_op_t;

endpackage

[hdl/double_ended_queue_with_removal_core.sv]
// Channel  Direction  Handshake              Payload
// cmd      in         cmd_valid / cmd_stall  dqr_pkg::dqr_cmd_t
// rsp      out        rsp_valid / rsp_stall  dqr_pkg::dqr_rsp_t
//
// Append, insert, take front and take back: the cell row executes when the
// command is accepted, and the result register is loaded in the report state.
// Delete matching: one matching entry removed per cycle in the delete state, then report.
// arst_n clears the controller, the entry count and the result register.
// cmd_stall is high from acceptance until the result is registered; a stalled
// rsp holds the finished transaction while the next command is taken.
module double_ended_queue_with_removal_core #(
	parameter int DEPTH      = dqr_pkg::DEFAULT_DEPTH,
	parameter int DATA_WIDTH = dqr_pkg::DEFAULT_DATA_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  dqr_pkg::dqr_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dqr_pkg::dqr_rsp_t rsp
);
	import dqr_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEL,
		ST_REPORT
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         occ_q;
	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [4:0]            limit_q;
	logic [1:0]            status_q;
	logic [DATA_WIDTH-1:0] taken_q;
	logic                  rsp_valid_q;
	dqr_rsp_t              rsp_q;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  del_mode;
	logic                  rm;
	logic                  pull_first;
	cell_op_t              cell_op;
	logic [DATA_WIDTH-1:0] word_in;
	logic [DATA_WIDTH-1:0] back_data;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] prev_data [DEPTH];
	logic [DATA_WIDTH-1:0] next_data [DEPTH];
	logic [DEPTH-1:0]      cell_sel;
	logic [DEPTH-1:0]      cell_check;
	logic [DEPTH-1:0]      cell_last;
	logic [DEPTH-1:0]      pull_in;
	logic [DEPTH-1:0]      pull_out;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && (state_q == ST_IDLE);
	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign del_mode  = (state_q == ST_DEL);
	assign word_in   = del_mode ? word_q : DATA_WIDTH'(cmd.item_value);
	assign rm        = pull_out[DEPTH-1] && (CMPW'(cnt_q) < CMPW'(limit_q));
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		cell_op    = CELL_HOLD;
		pull_first = 1'b0;
		if (accept) begin
			unique case (cmd.cmd)
				CMD_APPEND_BACK: begin
					if (!full) begin
						cell_op = CELL_LOAD;
					end
				end
				CMD_INSERT_FRONT: begin
					if (!full) begin
						cell_op = CELL_PUSH;
					end
				end
				CMD_TAKE_FRONT: begin
					if (!empty) begin
						cell_op    = CELL_PULL;
						pull_first = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (del_mode && rm) begin
			cell_op = CELL_PULL;
		end
	end

	always_comb begin
		back_data = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (cell_last[k]) begin
				back_data = back_data | cell_data[k];
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_sel[i]   = (occ_q == CW'(i));
		assign cell_check[i] = del_mode && (CW'(i) < occ_q);
		assign cell_last[i]  = (occ_q == CW'(i + 1));

		if (i == 0) begin : g_head
			assign prev_data[i] = word_in;
			assign pull_in[i]   = pull_first;
		end else begin : g_body
			assign prev_data[i] = cell_data[i-1];
			assign pull_in[i]   = pull_out[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_data[i] = cell_data[i];
		end else begin : g_inner
			assign next_data[i] = cell_data[i+1];
		end

		dqr_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.op       (cell_op),
			.word     (word_in),
			.sel      (cell_sel[i]),
			.check    (cell_check[i]),
			.prev_data(prev_data[i]),
			.next_data(next_data[i]),
			.pull_in  (pull_in[i]),
			.pull_out (pull_out[i]),
			.data     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			cnt_q       <= '0;
			word_q      <= '0;
			limit_q     <= '0;
			status_q    <= STATUS_OK;
			taken_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != ST_REPORT)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						word_q  <= DATA_WIDTH'(cmd.item_value);
						limit_q <= cmd.remove_limit;
						cnt_q   <= '0;
						state_q <= (cmd.cmd == CMD_DELETE_MATCH) ? ST_DEL : ST_REPORT;
						case (cmd.cmd) inside
							CMD_APPEND_BACK, CMD_INSERT_FRONT: begin
								taken_q <= '0;
								if (full) begin
									status_q <= STATUS_FULL;
								end else begin
									status_q <= STATUS_OK;
									occ_q    <= occ_q + CW'(1);
								end
							end
							CMD_TAKE_FRONT: begin
								if (empty) begin
									status_q <= STATUS_EMPTY;
									taken_q  <= '0;
								end else begin
									status_q <= STATUS_OK;
									taken_q  <= cell_data[0];
									occ_q    <= occ_q - CW'(1);
								end
							end
							CMD_TAKE_BACK: begin
								if (empty) begin
									status_q <= STATUS_EMPTY;
									taken_q  <= '0;
								end else begin
									status_q <= STATUS_OK;
									taken_q  <= back_data;
									occ_q    <= occ_q - CW'(1);
								end
							end
							default: begin
								status_q <= STATUS_OK;
								taken_q  <= '0;
							end
						endcase
					end
				end
				ST_DEL: begin
					if (rm) begin
						cnt_q <= cnt_q + CW'(1);
						occ_q <= occ_q - CW'(1);
					end else begin
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status        <= status_q;
						rsp_q.taken_value   <= 32'(taken_q);
						rsp_q.deleted_count <= 5'(cnt_q);
						rsp_q.entry_count   <= 5'(occ_q);
						rsp_q.is_empty      <= empty;
						rsp_q.front_value   <= empty ? '0 : 32'(cell_data[0]);
						rsp_q.back_value    <= empty ? '0 : 32'(back_data);
						rsp_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/dqr_cell.sv]
module dqr_cell #(
	parameter int DATA_WIDTH = dqr_pkg::DEFAULT_DATA_WIDTH
) (
	input  logic                  clk,
	input  dqr_pkg::cell_op_t     op,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic                  sel,
	input  logic                  check,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	input  logic                  pull_in,
	output logic                  pull_out,
	output logic [DATA_WIDTH-1:0] data
);
	import dqr_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  match;

	assign match    = check && (data_q == word);
	assign pull_out = pull_in || match;
	assign data     = data_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD: begin
			end
			CELL_LOAD: begin
				if (sel) begin
					data_q <= word;
				end
			end
			CELL_PUSH: begin
				data_q <= prev_data;
			end
			CELL_PULL: begin
				// close the gap: this cell and all behind the removed one advance
				if (pull_out) begin
					data_q <= next_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/dqr_checker.sv]
`include "double_ended_queue_with_removal_core_macros.svh"

module dqr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input dqr_pkg::dqr_cmd_t cmd,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input dqr_pkg::dqr_rsp_t rsp
);
	import dqr_pkg::*;

	`DQR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled rsp transaction changed")
	`DQR_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall, "cmd accepted twice in a row")
	`DQR_ASSERT_NOW(a_empty_flag, clk, arst_n, rsp_valid, rsp.is_empty == (rsp.entry_count == 5'd0), "is_empty disagrees with entry_count")
	`DQR_ASSERT_NOW(a_empty_ends, clk, arst_n, rsp_valid && rsp.is_empty, (rsp.front_value == 32'd0) && (rsp.back_value == 32'd0), "empty deque reports nonzero ends")
	`DQR_ASSERT_NOW(a_take_empty, clk, arst_n, rsp_valid && (rsp.status == STATUS_EMPTY), (rsp.taken_value == 32'd0) && rsp.is_empty, "take from empty returned data")

endmodule

bind double_ended_queue_with_removal_core dqr_checker u_dqr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd      (cmd),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import dqr_pkg::*;

	localparam int DEPTH        = DEFAULT_DEPTH;
	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int TIMEOUT_NS   = 1_000_000;

	typedef enum int unsigned {
		MIX_FILL,
		MIX_DRAIN,
		MIX_PRUNE,
		MIX_NOISE
	} mix_t;

	class deque_tracker;
		logic [31:0] words [DEPTH];
		int unsigned held;
		dqr_rsp_t    awaited_rsp [$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned full_rejects;
		int unsigned empty_takes;
		int unsigned deleted_total;
		int unsigned unused_cmds;
		int unsigned per_cmd [8];

		function void note_command(dqr_cmd_t c);
			dqr_rsp_t    r;
			int unsigned rd;
			int unsigned wr;
			r = '0;
			r.status = STATUS_OK;
			per_cmd[c.cmd]++;
			case (c.cmd)
				CMD_APPEND_BACK: begin
					if (held >= DEPTH) begin
						r.status = STATUS_FULL;
					end else begin
						words[held] = c.item_value;
						held++;
					end
				end
				CMD_INSERT_FRONT: begin
					if (held >= DEPTH) begin
						r.status = STATUS_FULL;
					end else begin
						for (rd = held; rd > 0; rd--)
							words[rd] = words[rd - 1];
						words[0] = c.item_value;
						held++;
					end
				end
				CMD_TAKE_FRONT: begin
					if (held == 0) begin
						r.status = STATUS_EMPTY;
					end else begin
						r.taken_value = words[0];
						for (rd = 0; rd + 1 < held; rd++)
							words[rd] = words[rd + 1];
						held--;
					end
				end
				CMD_TAKE_BACK: begin
					if (held == 0) begin
						r.status = STATUS_EMPTY;
					end else begin
						r.taken_value = words[held - 1];
						held--;
					end
				end
				CMD_DELETE_MATCH: begin
					wr = 0;
					for (rd = 0; rd < held; rd++) begin
						if (r.deleted_count < c.remove_limit && words[rd] == c.item_value) begin
							r.deleted_count = r.deleted_count + 5'd1;
						end else begin
							words[wr] = words[rd];
							wr++;
						end
					end
					held = wr;
					deleted_total += r.deleted_count;
				end
				default: begin
					unused_cmds++;
				end
			endcase
			if (r.status == STATUS_FULL)
				full_rejects++;
			if (r.status == STATUS_EMPTY)
				empty_takes++;
			r.entry_count = 5'(held);
			r.is_empty    = (held == 0);
			r.front_value = (held != 0) ? words[0] : 32'd0;
			r.back_value  = (held != 0) ? words[held - 1] : 32'd0;
			awaited_rsp.push_back(r);
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			if (mismatches < 10)
				$display("mismatch at result %0d: %s expected %h got %h",
					checked, what, want, got);
			mismatches++;
		endfunction

		function void compare(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got)
				flag(what, want, got);
		endfunction

		function void check_response(dqr_rsp_t got);
			dqr_rsp_t want;
			if (awaited_rsp.size() == 0) begin
				flag("unexpected result, status", 32'd0, 32'(got.status));
				return;
			end
			want = awaited_rsp.pop_front();
			compare("status", 32'(want.status), 32'(got.status));
			compare("taken_value", want.taken_value, got.taken_value);
			compare("deleted_count", 32'(want.deleted_count), 32'(got.deleted_count));
			compare("entry_count", 32'(want.entry_count), 32'(got.entry_count));
			compare("is_empty", 32'(want.is_empty), 32'(got.is_empty));
			compare("front_value", want.front_value, got.front_value);
			compare("back_value", want.back_value, got.back_value);
			checked++;
		endfunction

		function int unsigned pending();
			return awaited_rsp.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     cmd_valid;
	logic     cmd_stall;
	dqr_cmd_t cmd;
	logic     rsp_valid;
	logic     rsp_stall;
	dqr_rsp_t rsp;

	deque_tracker sb = new;
	bit           send_idle;

	double_ended_queue_with_removal_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic dqr_cmd_t pick_cmd(mix_t mix);
		dqr_cmd_t    c;
		int unsigned roll;
		int unsigned push_cut;
		int unsigned take_cut;
		int unsigned del_cut;
		logic [31:0] pool [8];
		pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
			32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0007, 32'h1234_5678};
		case (mix)
			MIX_FILL:  begin push_cut = 80; take_cut = 90; del_cut = 97; end
			MIX_DRAIN: begin push_cut = 25; take_cut = 85; del_cut = 95; end
			MIX_PRUNE: begin push_cut = 55; take_cut = 70; del_cut = 97; end
			default:   begin push_cut = 30; take_cut = 55; del_cut = 75; end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < push_cut)
			c.cmd = $urandom_range(0, 1) ? CMD_APPEND_BACK : CMD_INSERT_FRONT;
		else if (roll < take_cut)
			c.cmd = $urandom_range(0, 1) ? CMD_TAKE_FRONT : CMD_TAKE_BACK;
		else if (roll < del_cut)
			c.cmd = CMD_DELETE_MATCH;
		else
			c.cmd = CMD_DELETE_MATCH + 3'($urandom_range(1, 3));
		c.item_value   = ($urandom_range(0, 3) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
		c.remove_limit = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 16))
			: 5'($urandom_range(0, 31));
		return c;
	endfunction

	task automatic offer(input dqr_cmd_t c);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		sb.note_command(c);
	endtask

	initial begin
		int unsigned gap;
		int unsigned taken;
		bit          quiet;
		rsp_stall <= 1'b1;
		taken = 0;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 64 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			gap = quiet ? 0 : $urandom_range(0, 9);
			if (taken == 300)
				gap = LONG_HOLD;
			rsp_stall <= (gap != 0);
			repeat (gap) @(posedge clk);
			if (gap != 0)
				rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			sb.check_response(rsp);
			taken++;
		end
	end

	initial begin
		dqr_cmd_t    c;
		mix_t        mix;
		int unsigned sent;
		int unsigned seg;
		int unsigned seg_len;
		int unsigned k;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		send_idle = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(dqr_cmd_t'{CMD_TAKE_FRONT, 32'h0000_0000, 5'd0});
		offer(dqr_cmd_t'{CMD_TAKE_BACK, 32'hFFFF_FFFF, 5'd31});
		offer(dqr_cmd_t'{CMD_DELETE_MATCH, 32'h0000_0000, 5'd16});
		offer(dqr_cmd_t'{CMD_DELETE_MATCH + 3'd1, 32'hFFFF_FFFF, 5'd31});
		offer(dqr_cmd_t'{CMD_APPEND_BACK, 32'h0000_0000, 5'd0});
		offer(dqr_cmd_t'{CMD_INSERT_FRONT, 32'hFFFF_FFFF, 5'd31});
		offer(dqr_cmd_t'{CMD_APPEND_BACK, 32'hFFFF_FFFF, 5'd0});
		offer(dqr_cmd_t'{CMD_INSERT_FRONT, 32'h0000_0000, 5'd0});
		offer(dqr_cmd_t'{CMD_APPEND_BACK, 32'h1234_5678, 5'd0});
		offer(dqr_cmd_t'{CMD_APPEND_BACK, 32'h0000_0000, 5'd0});
		offer(dqr_cmd_t'{CMD_DELETE_MATCH, 32'h0000_0000, 5'd0});
		offer(dqr_cmd_t'{CMD_DELETE_MATCH, 32'hFFFF_FFFF, 5'd1});
		offer(dqr_cmd_t'{CMD_DELETE_MATCH, 32'h0000_0000, 5'd31});
		offer(dqr_cmd_t'{CMD_DELETE_MATCH + 3'd2, 32'hA5A5_A5A5, 5'd16});
		offer(dqr_cmd_t'{CMD_DELETE_MATCH + 3'd3, 32'h5A5A_5A5A, 5'd1});
		offer(dqr_cmd_t'{CMD_TAKE_FRONT, 32'h0000_0000, 5'd0});
		offer(dqr_cmd_t'{CMD_TAKE_BACK, 32'h0000_0000, 5'd0});
		offer(dqr_cmd_t'{CMD_TAKE_BACK, 32'h0000_0000, 5'd0});
		offer(dqr_cmd_t'{CMD_TAKE_FRONT, 32'h0000_0000, 5'd0});
		for (k = 0; k < DEPTH + 2; k++)
			offer(dqr_cmd_t'{(k[0] ? CMD_INSERT_FRONT : CMD_APPEND_BACK), 32'h8000_0001, 5'd0});
		offer(dqr_cmd_t'{CMD_DELETE_MATCH, 32'h8000_0001, 5'd20});

		sent = 0;
		seg  = 0;
		while (sent < RANDOM_ITEMS) begin
			mix       = (seg == 0) ? MIX_FILL : mix_t'($urandom_range(0, 3));
			seg_len   = $urandom_range(20, 60);
			send_idle = ($urandom_range(0, 3) != 0);
			if (seg == 8) begin
				cmd_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			for (k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
				c = pick_cmd(mix);
				offer(c);
				if (c.cmd <= CMD_DELETE_MATCH)
					sent++;
			end
			seg++;
		end

		cmd_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d appends, %0d front inserts, %0d front takes, %0d back takes, %0d deletes, %0d unused commands",
			sb.per_cmd[CMD_APPEND_BACK], sb.per_cmd[CMD_INSERT_FRONT],
			sb.per_cmd[CMD_TAKE_FRONT], sb.per_cmd[CMD_TAKE_BACK],
			sb.per_cmd[CMD_DELETE_MATCH], sb.unused_cmds);
		$display("%0d pushes rejected as full, %0d takes on empty, %0d words deleted by value, %0d results checked",
			sb.full_rejects, sb.empty_takes, sb.deleted_total, sb.checked);
		if (sb.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
